FILE: sv/aesg_pkg.sv
package aesg_pkg;

   // Operation codes carried by an input transaction.
   typedef enum logic [1:0] {
      OP_AAD    = 2'd0,
      OP_TEXT   = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Result kinds carried by an output transaction.
   typedef enum logic [1:0] {
      KIND_CIPHER = 2'd0,
      KIND_TAG    = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_KEY_HI = 2'd0,
      CSR_KEY_LO = 2'd1,
      CSR_IV_HI  = 2'd2,
      CSR_IV_LO  = 2'd3
   } csr_type;

   // One queued work item between the front and the back.
   typedef struct packed {
      op_type       op;
      logic [127:0] data;
   } item_type;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0]  LAST_ROUND  = 4'd10;
   localparam logic [3:0]  GHASH_LAST  = 4'd15;
   localparam logic [7:0]  RCON_FIRST  = 8'h01;
   localparam logic [7:0]  GHASH_POLY  = 8'he1;
   localparam logic [31:0] CTR_START   = 32'd2;
   localparam logic [31:0] CTR_TAG     = 32'd1;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
   endfunction

   // Next AES-128 round key from the current one.
   function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] w3;
      logic [31:0] t;
      logic [31:0] n0;
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] n3;
      w3 = rk[31:0];
      t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
           ^ {rcon, 24'd0};
      n0 = rk[127:96] ^ t;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // One AES round; the final round skips the column mix.
   function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         s[i] = st[127 - 8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c + r] = SBOX[s[4*((c + r) & 3) + r]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         if (last) begin
            s[4*c]   = t[4*c];
            s[4*c+1] = t[4*c+1];
            s[4*c+2] = t[4*c+2];
            s[4*c+3] = t[4*c+3];
         end else begin
            s[4*c]   = t[4*c]   ^ all ^ gf_dbl(t[4*c]   ^ t[4*c+1]);
            s[4*c+1] = t[4*c+1] ^ all ^ gf_dbl(t[4*c+1] ^ t[4*c+2]);
            s[4*c+2] = t[4*c+2] ^ all ^ gf_dbl(t[4*c+2] ^ t[4*c+3]);
            s[4*c+3] = t[4*c+3] ^ all ^ gf_dbl(t[4*c+3] ^ t[4*c]);
         end
      end
      for (int i = 0; i < 16; i++) begin
         res[127 - 8*i -: 8] = s[i];
      end
      return res ^ rk;
   endfunction

   // Eight bits of the GF(2^128) multiply; returns {z, v}.
   function automatic logic [255:0] ghash_step8(input logic [127:0] z_i, input logic [127:0] v_i,
                                                input logic [7:0] hb);
      logic [127:0] z;
      logic [127:0] v;
      logic         lsb;
      z = z_i;
      v = v_i;
      for (int i = 0; i < 8; i++) begin
         if (hb[7 - i]) begin
            z = z ^ v;
         end
         lsb = v[0];
         v   = {1'b0, v[127:1]};
         if (lsb) begin
            v[127:120] = v[127:120] ^ GHASH_POLY;
         end
      end
      return {z, v};
   endfunction

endpackage

FILE: sv/aes128_gcm_encrypt.sv
// AES-128-GCM encryption engine for whole 16-byte blocks and a 96-bit IV.
// Configuration: csr_we writes csr_wdata into the register chosen by csr_index
// (key high, key low, IV high, IV low); write it only while the engine is idle.
// A key write makes the next transaction first derive the hash subkey.
// Input channel: a transaction is taken when req_push is high and req_full is
// low. req_op selects additional data, plaintext or finish; op code three is
// taken and dropped. A two-entry queue decouples the input from the engine.
// Result channel: the oldest result sits on rsp_kind, rsp_out_hi and rsp_out_lo
// while rsp_empty is low and leaves when rsp_pop is high. Plaintext returns a
// ciphertext block, finish returns the tag, and additional data after text
// returns an ordering error with zero data.
// Steps per transaction in the engine: additional data takes a fetch step, a
// decode step and a GHASH multiply at eight key bits a cycle; plaintext takes
// fetch, decode, 10 AES rounds at one round a cycle, the multiply and an emit
// step; finish takes fetch, decode, the multiply, the rounds and an emit step.
// The first transaction after a key write first runs the rounds for the hash subkey.
// If the result is not popped, the engine holds in its emit step while the
// input queue keeps taking transactions until it fills.
// Reset (synchronous) empties the input queue and the result register, clears
// the message state and forces a new hash subkey; config registers reset to zero.
module aes128_gcm_encrypt #(
   parameter int QUEUE_DEPTH = aesg_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_out_hi,
   output logic [63:0] rsp_out_lo,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0] key_hi_ff, key_hi_in;
   logic [63:0] key_lo_ff, key_lo_in;
   logic [31:0] iv_hi_ff, iv_hi_in;
   logic [63:0] iv_lo_ff, iv_lo_in;
   logic        key_changed;

   aesg_pkg::item_type item;
   logic               item_valid;
   logic               item_pop;
   aesg_pkg::kind_type kind;
   logic [127:0]       rsp_data;

   // Configuration write decode. Key writes also invalidate the hash subkey.
   always_comb begin
      key_hi_in   = key_hi_ff;
      key_lo_in   = key_lo_ff;
      iv_hi_in    = iv_hi_ff;
      iv_lo_in    = iv_lo_ff;
      key_changed = 1'b0;
      if (csr_we) begin
         unique case (aesg_pkg::csr_type'(csr_index))
            aesg_pkg::CSR_KEY_HI: begin
               key_hi_in   = csr_wdata;
               key_changed = 1'b1;
            end
            aesg_pkg::CSR_KEY_LO: begin
               key_lo_in   = csr_wdata;
               key_changed = 1'b1;
            end
            aesg_pkg::CSR_IV_HI: begin
               iv_hi_in = csr_wdata[31:0];
            end
            aesg_pkg::CSR_IV_LO: begin
               iv_lo_in = csr_wdata;
            end
            default: begin
               key_changed = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
      end else begin
         key_hi_ff <= key_hi_in;
         key_lo_ff <= key_lo_in;
         iv_hi_ff  <= iv_hi_in;
         iv_lo_ff  <= iv_lo_in;
      end
   end

   // Front: accepts transactions and queues the ones that need work.
   aesg_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_op     (aesg_pkg::op_type'(req_op)),
      .req_data   ({req_data_hi, req_data_lo}),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // Back: cipher rounds, GHASH multiply, message state and result register.
   aesg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .key         ({key_hi_ff, key_lo_ff}),
      .iv          ({iv_hi_ff, iv_lo_ff}),
      .key_changed (key_changed),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_kind    (kind),
      .rsp_data    (rsp_data)
   );

   assign rsp_kind   = kind;
   assign rsp_out_hi = rsp_data[127:64];
   assign rsp_out_lo = rsp_data[63:0];

endmodule

FILE: sv/aesg_front.sv
module aesg_front #(
   parameter int DEPTH = aesg_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  aesg_pkg::op_type   req_op,
   input  logic [127:0]       req_data,
   output logic               item_valid,
   output aesg_pkg::item_type item,
   input  logic               item_pop
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   aesg_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          store;
   logic          take;

   assign req_full   = (cnt_ff == CW'(DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = mem_ff[rptr_ff];

   // The unused op code is accepted and dropped here.
   assign store = req_push && !req_full && (req_op != aesg_pkg::OP_NONE);
   assign take  = item_pop && item_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (store) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (take) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (store && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !store) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem_ff[wptr_ff] <= '{op: req_op, data: req_data};
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("front queue count exceeds depth");

   a_drop_none: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_op == aesg_pkg::OP_NONE && !take) |=> $stable(cnt_ff))
      else $error("unused op code entered the queue");

endmodule

FILE: sv/aesg_back.sv
module aesg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  aesg_pkg::item_type item,
   output logic               item_pop,
   input  logic [127:0]       key,
   input  logic [95:0]        iv,
   input  logic               key_changed,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output aesg_pkg::kind_type rsp_kind,
   output logic [127:0]       rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_HKEY  = 6'b000100,
      ST_AES   = 6'b001000,
      ST_GHASH = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   aesg_pkg::op_type   op_ff, op_in;
   logic [127:0]       data_ff, data_in;
   logic               keys_ready_ff, keys_ready_in;
   logic [127:0]       h_ff, h_in;
   logic [127:0]       acc_ff, acc_in;
   logic [31:0]        ctr_ff, ctr_in;
   logic [31:0]        aad_ff, aad_in;
   logic [31:0]        txt_ff, txt_in;
   logic [127:0]       st_ff, st_in;
   logic [127:0]       rk_ff, rk_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [3:0]         rnd_ff, rnd_in;
   logic [127:0]       z_ff, z_in;
   logic [127:0]       v_ff, v_in;
   logic [127:0]       hsh_ff, hsh_in;
   logic [3:0]         gcnt_ff, gcnt_in;
   aesg_pkg::kind_type res_kind_ff, res_kind_in;
   logic [127:0]       res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   aesg_pkg::kind_type out_kind_ff, out_kind_in;
   logic [127:0]       out_data_ff, out_data_in;

   logic [127:0] rk_nxt;
   logic [127:0] aes_nxt;
   logic [255:0] gh_nxt;
   logic [127:0] ct;

   assign rk_nxt  = aesg_pkg::key_next(rk_ff, rcon_ff);
   assign aes_nxt = aesg_pkg::aes_round(st_ff, rk_nxt, rnd_ff == aesg_pkg::LAST_ROUND);
   assign gh_nxt  = aesg_pkg::ghash_step8(z_ff, v_ff, hsh_ff[127:120]);
   assign ct      = aes_nxt ^ data_ff;

   assign rsp_empty = !out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      data_in       = data_ff;
      keys_ready_in = keys_ready_ff;
      h_in          = h_ff;
      acc_in        = acc_ff;
      ctr_in        = ctr_ff;
      aad_in        = aad_ff;
      txt_in        = txt_ff;
      st_in         = st_ff;
      rk_in         = rk_ff;
      rcon_in       = rcon_ff;
      rnd_in        = rnd_ff;
      z_in          = z_ff;
      v_in          = v_ff;
      hsh_in        = hsh_ff;
      gcnt_in       = gcnt_ff;
      res_kind_in   = res_kind_ff;
      res_in        = res_ff;
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_data_in   = out_data_ff;
      item_pop      = 1'b0;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               op_in    = item.op;
               data_in  = item.data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (!keys_ready_ff) begin
               // Hash subkey is the cipher of the all-zero block.
               st_in    = key;
               rk_in    = key;
               rcon_in  = aesg_pkg::RCON_FIRST;
               rnd_in   = 4'd1;
               state_in = ST_HKEY;
            end else begin
               unique case (op_ff)
                  aesg_pkg::OP_AAD: begin
                     if (txt_ff != '0) begin
                        res_kind_in = aesg_pkg::KIND_ERROR;
                        res_in      = '0;
                        state_in    = ST_EMIT;
                     end else begin
                        z_in     = '0;
                        v_in     = acc_ff ^ data_ff;
                        hsh_in   = h_ff;
                        gcnt_in  = '0;
                        state_in = ST_GHASH;
                     end
                  end
                  aesg_pkg::OP_TEXT: begin
                     st_in    = {iv, ctr_ff} ^ key;
                     rk_in    = key;
                     rcon_in  = aesg_pkg::RCON_FIRST;
                     rnd_in   = 4'd1;
                     state_in = ST_AES;
                  end
                  aesg_pkg::OP_FINISH: begin
                     z_in     = '0;
                     v_in     = acc_ff ^ {25'd0, aad_ff, 7'd0, 25'd0, txt_ff, 7'd0};
                     hsh_in   = h_ff;
                     gcnt_in  = '0;
                     state_in = ST_GHASH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_HKEY: begin
            st_in   = aes_nxt;
            rk_in   = rk_nxt;
            rcon_in = aesg_pkg::gf_dbl(rcon_ff);
            rnd_in  = rnd_ff + 1'b1;
            if (rnd_ff == aesg_pkg::LAST_ROUND) begin
               h_in          = aes_nxt;
               keys_ready_in = 1'b1;
               state_in      = ST_PREP;
            end
         end
         ST_AES: begin
            st_in   = aes_nxt;
            rk_in   = rk_nxt;
            rcon_in = aesg_pkg::gf_dbl(rcon_ff);
            rnd_in  = rnd_ff + 1'b1;
            if (rnd_ff == aesg_pkg::LAST_ROUND) begin
               if (op_ff == aesg_pkg::OP_TEXT) begin
                  res_kind_in = aesg_pkg::KIND_CIPHER;
                  res_in      = ct;
                  z_in        = '0;
                  v_in        = acc_ff ^ ct;
                  hsh_in      = h_ff;
                  gcnt_in     = '0;
                  txt_in      = txt_ff + 1'b1;
                  ctr_in      = ctr_ff + 1'b1;
                  state_in    = ST_GHASH;
               end else begin
                  res_kind_in = aesg_pkg::KIND_TAG;
                  res_in      = aes_nxt ^ acc_ff;
                  acc_in      = '0;
                  ctr_in      = aesg_pkg::CTR_START;
                  aad_in      = '0;
                  txt_in      = '0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_GHASH: begin
            z_in    = gh_nxt[255:128];
            v_in    = gh_nxt[127:0];
            hsh_in  = {hsh_ff[119:0], 8'd0};
            gcnt_in = gcnt_ff + 1'b1;
            if (gcnt_ff == aesg_pkg::GHASH_LAST) begin
               acc_in = gh_nxt[255:128];
               priority if (op_ff == aesg_pkg::OP_AAD) begin
                  aad_in   = aad_ff + 1'b1;
                  state_in = ST_IDLE;
               end else if (op_ff == aesg_pkg::OP_TEXT) begin
                  state_in = ST_EMIT;
               end else begin
                  st_in    = {iv, aesg_pkg::CTR_TAG} ^ key;
                  rk_in    = key;
                  rcon_in  = aesg_pkg::RCON_FIRST;
                  rnd_in   = 4'd1;
                  state_in = ST_AES;
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_kind_in  = res_kind_ff;
               out_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (key_changed) begin
         keys_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         acc_ff        <= '0;
         ctr_ff        <= aesg_pkg::CTR_START;
         aad_ff        <= '0;
         txt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         acc_ff        <= acc_in;
         ctr_ff        <= ctr_in;
         aad_ff        <= aad_in;
         txt_ff        <= txt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      data_ff     <= data_in;
      h_ff        <= h_in;
      st_ff       <= st_in;
      rk_ff       <= rk_in;
      rcon_ff     <= rcon_in;
      rnd_ff      <= rnd_in;
      z_ff        <= z_in;
      v_ff        <= v_in;
      hsh_ff      <= hsh_in;
      gcnt_ff     <= gcnt_in;
      res_kind_ff <= res_kind_in;
      res_ff      <= res_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
   end

   a_keys_from_hkey: assert property (@(posedge clock) disable iff (reset)
      $rose(keys_ready_ff) |-> $past(state_ff == ST_HKEY))
      else $error("keys marked ready without computing the hash subkey");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AES || state_ff == ST_HKEY) |->
         (rnd_ff != 4'd0 && rnd_ff <= aesg_pkg::LAST_ROUND))
      else $error("cipher round counter out of range");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_valid_ff) |=> (out_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into the output register");

endmodule
